/* rtl/mctt_pkg.sv */
// Package: shared constants, operation codes and lane control types for the timer bank.
`timescale 1ns / 1ps
`default_nettype none

package mctt_pkg;

  // Bank geometry
  localparam int MAX_TIMERS  = 8;
  localparam int COUNT_WIDTH = 16;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int IDX_W    = 3;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 4;
  localparam int MASK_W   = 8;

  // Operation codes; the fourth code is a no-op
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Command broadcast to every lane
  typedef struct packed {
    logic                go;
    op_t                 op;
    logic [PERIOD_W-1:0] period;
    logic                auto_reload;
  } lane_cmd_t;

  // Per-lane flags as they stand after the current command
  typedef struct packed {
    logic fired;
    logic running;
  } lane_stat_t;

endpackage : mctt_pkg

`default_nettype wire

/* rtl/mctt_if.sv */
// Interfaces: valid/ready channels for the command word and the status word.
`timescale 1ns / 1ps
`default_nettype none

interface mctt_in_if import mctt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_W-1:0]    timer_index;
  logic [PERIOD_W-1:0] period;
  logic                auto_reload;

  modport source (output valid, op, timer_index, period, auto_reload, input ready);
  modport sink   (input valid, op, timer_index, period, auto_reload, output ready);
endinterface : mctt_in_if

interface mctt_out_if import mctt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fired_mask;
  logic [MASK_W-1:0] running_mask;

  modport source (output valid, fired_mask, running_mask, input ready);
  modport sink   (input valid, fired_mask, running_mask, output ready);
endinterface : mctt_out_if

`default_nettype wire

/* rtl/mctt_timer_lane.sv */
// One timer lane: down-counter, reload value, mode and status flags.
`timescale 1ns / 1ps
`default_nettype none

module mctt_timer_lane import mctt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lane_cmd_t  cmd,
  input  wire logic       sel,      // start/clear addresses this lane
  input  wire logic       tick_en,  // lane index below the active count
  output lane_stat_t      stat_nxt
);

  logic [COUNT_WIDTH-1:0] count_r,  count_nxt;
  logic [COUNT_WIDTH-1:0] reload_r, reload_nxt;
  logic                   mode_r,   mode_nxt;
  logic                   running_r, running_nxt;
  logic                   fired_r,   fired_nxt;
  logic [COUNT_WIDTH-1:0] start_val;

  // period minus one, wrapping so zero gives all ones
  assign start_val = COUNT_WIDTH'(cmd.period) - COUNT_WIDTH'(1);

  // Next-state logic
  always_comb begin
    count_nxt   = count_r;
    reload_nxt  = reload_r;
    mode_nxt    = mode_r;
    running_nxt = running_r;
    fired_nxt   = fired_r;
    if (cmd.go) begin
      unique case (cmd.op)
        OP_TICK: begin
          if (tick_en && running_r) begin
            if (count_r != '0) begin
              count_nxt = count_r - COUNT_WIDTH'(1);
            end else begin
              fired_nxt = 1'b1;
              if (mode_r) begin
                count_nxt = reload_r;
              end else begin
                running_nxt = 1'b0;
              end
            end
          end
        end
        OP_START: begin
          if (sel) begin
            count_nxt   = start_val;
            reload_nxt  = start_val;
            mode_nxt    = cmd.auto_reload;
            running_nxt = 1'b1;
            fired_nxt   = 1'b0;
          end
        end
        OP_CLEAR: begin
          if (sel) begin
            fired_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      fired_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      fired_r   <= fired_nxt;
    end
  end

  // Count and settings, only meaningful once started
  always_ff @(posedge clk) begin
    count_r  <= count_nxt;
    reload_r <= reload_nxt;
    mode_r   <= mode_nxt;
  end

  assign stat_nxt.fired   = fired_nxt;
  assign stat_nxt.running = running_nxt;

  // fired only sets on a tick that reaches this lane
  a_fire_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (fired_r && !$past(fired_r)) |->
      $past(cmd.go && cmd.op == OP_TICK && tick_en && running_r))
    else $error("fired flag set outside a serviced tick");

  // running only sets on a start that addresses this lane
  a_run_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (running_r && !$past(running_r)) |-> $past(cmd.go && cmd.op == OP_START && sel))
    else $error("running flag set without a start");

endmodule : mctt_timer_lane

`default_nettype wire

/* rtl/multi_channel_tick_timer_bank.sv */
// Top level: input register, timer lanes and the status output register.
// Path: a command word is held in the input register, its status word in the output register.
// Throughput: one command word per cycle while the output does not stall; all lanes update in the same cycle.
// in_chan.ready falls only while the input register holds a word and the output stalls.
// Reset (rst_n low, synchronous): all timers stopped, fired flags clear,
// active count 0, both channel registers empty.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_tick_timer_bank import mctt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mctt_in_if.sink               in_chan,
  mctt_out_if.source            out_chan,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  logic [CFG_W-1:0]    cfg_r;
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [IDX_W-1:0]    s1_index_r;
  logic [PERIOD_W-1:0] s1_period_r;
  logic                s1_auto_r;
  logic                s1_go;
  logic                in_take;
  logic                out_valid_r;
  logic [MASK_W-1:0]   fired_mask_r, fired_mask_nxt;
  logic [MASK_W-1:0]   running_mask_r, running_mask_nxt;
  lane_cmd_t           cmd;
  lane_stat_t          stat [MAX_TIMERS];

  // Handshake
  assign s1_go          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_go;
  assign in_take        = in_chan.valid && in_chan.ready;

  // Active timer count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r     <= in_chan.op;
      s1_index_r  <= in_chan.timer_index;
      s1_period_r <= in_chan.period;
      s1_auto_r   <= in_chan.auto_reload;
    end
  end

  // Command broadcast
  assign cmd.go          = s1_go;
  assign cmd.op          = op_t'(s1_op_r);
  assign cmd.period      = s1_period_r;
  assign cmd.auto_reload = s1_auto_r;

  // Timer lanes
  for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_lane
    logic sel;
    logic tick_en;
    assign sel     = (32'(s1_index_r) == i);
    assign tick_en = (32'(cfg_r) > i);

    mctt_timer_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .sel      (sel),
      .tick_en  (tick_en),
      .stat_nxt (stat[i])
    );
  end

  // Status masks: one bit per lane, any bits above the lane count tied to zero
  for (genvar j = 0; j < MASK_W; j++) begin : g_mask
    if (j < MAX_TIMERS) begin : g_bit
      assign fired_mask_nxt[j]   = stat[j].fired;
      assign running_mask_nxt[j] = stat[j].running;
    end else begin : g_zero
      assign fired_mask_nxt[j]   = 1'b0;
      assign running_mask_nxt[j] = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      fired_mask_r   <= fired_mask_nxt;
      running_mask_r <= running_mask_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.fired_mask   = fired_mask_r;
  assign out_chan.running_mask = running_mask_r;

  // An accepted word always lands in the input register
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted word lost at input register");

  // A word leaving the input register always produces a result
  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("processed word produced no result");

  // Input register never holds a word stalled while the output register is empty
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |-> s1_go)
    else $error("input register stalled with free output");

endmodule : multi_channel_tick_timer_bank

`default_nettype wire
